// ===== sv/hcvc_pkg.sv =====
// hcvc_pkg: shared widths, colour codes, register indices and reset values
// for the HSV colour vote classifier. No dependencies.
`default_nettype none

package hcvc_pkg;

	// Field widths fixed by the pixel and result formats
	localparam int unsigned PIX_W      = 8;
	localparam int unsigned COLOR_W    = 2;
	localparam int unsigned TOTAL_W    = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 8;

	typedef logic [PIX_W-1:0]   pix_t;
	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [TOTAL_W-1:0] total_t;

	// Colour codes
	localparam color_t COLOR_NONE   = 2'd0;
	localparam color_t COLOR_RED    = 2'd1;
	localparam color_t COLOR_BLUE   = 2'd2;
	localparam color_t COLOR_PURPLE = 2'd3;

	// Register indices
	localparam logic [CFG_IDX_W-1:0] REG_VOTE_RULE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAT_MIN       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VAL_MIN       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VAL_MAX       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PURPLE_HUE_LO = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PURPLE_HUE_HI = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_HUE_LO   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_HUE_HI   = 3'd7;

	// Register reset values
	localparam pix_t RST_SAT_MIN       = 8'd43;
	localparam pix_t RST_VAL_MIN       = 8'd46;
	localparam pix_t RST_VAL_MAX       = 8'd240;
	localparam pix_t RST_PURPLE_HUE_LO = 8'd125;
	localparam pix_t RST_PURPLE_HUE_HI = 8'd155;
	localparam pix_t RST_BLUE_HUE_LO   = 8'd100;
	localparam pix_t RST_BLUE_HUE_HI   = 8'd124;

	// Fixed red hue band, wrapping round zero
	localparam pix_t RED_HUE_LO  = 8'd156;
	localparam pix_t RED_HUE_HI  = 8'd180;
	localparam pix_t RED_WRAP_HI = 8'd10;

	localparam total_t TOTAL_MAX = {TOTAL_W{1'b1}};

	// Configuration register set
	typedef struct packed {
		logic vote_rule;
		pix_t sat_min;
		pix_t val_min;
		pix_t val_max;
		pix_t purple_hue_lo;
		pix_t purple_hue_hi;
		pix_t blue_hue_lo;
		pix_t blue_hue_hi;
	} cfg_t;

endpackage

`default_nettype wire

// ===== sv/hcvc_pixel_if.sv =====
// hcvc_pixel_if: valid/ready channel carrying one HSV pixel per transaction.
// Depends on hcvc_pkg.
`default_nettype none

interface hcvc_pixel_if;
	import hcvc_pkg::*;

	logic valid;
	logic ready;
	pix_t hue;
	pix_t sat;
	pix_t val;
	logic last_pixel;

	modport source (output valid, hue, sat, val, last_pixel, input ready);
	modport sink   (input valid, hue, sat, val, last_pixel, output ready);
endinterface

`default_nettype wire

// ===== sv/hcvc_result_if.sv =====
// hcvc_result_if: valid/ready channel carrying one colour decision and totals.
// Depends on hcvc_pkg.
`default_nettype none

interface hcvc_result_if;
	import hcvc_pkg::*;

	logic   valid;
	logic   ready;
	color_t color;
	total_t red_total;
	total_t blue_total;
	total_t purple_total;

	modport source (output valid, color, red_total, blue_total, purple_total, input ready);
	modport sink   (input valid, color, red_total, blue_total, purple_total, output ready);
endinterface

`default_nettype wire

// ===== sv/hsv_color_vote_classifier_top.sv =====
// Channel  | Dir | Transaction content
// ---------+-----+---------------------------------------------------------
// pix      | in  | hue, sat, val, last_pixel (one pixel)
// res      | out | color, red_total, blue_total, purple_total (per region)
// cfg_*    | in  | register index and data, written when cfg_we is high
//
// One pixel per cycle while no last pixel waits in s1; a pixel enters s1,
// updates the counters on leaving s1, and a last pixel's snapshot is
// decided in s2 and held in the output register, which offers the result.
// Reset clears valids and counters and loads the register defaults.
// A held result stalls only last pixels in s1; ordinary pixels keep flowing
// until a last pixel has to wait in s1, which then holds off the input.
// Holds hsv_color_vote_classifier_top; depends on hcvc_pkg and both interfaces.
`default_nettype none

module hsv_color_vote_classifier_top
	import hcvc_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	hcvc_pixel_if.sink                 pix,
	hcvc_result_if.source              res
);

	localparam int unsigned SUM_W = COUNT_WIDTH + 2;
	localparam int unsigned EXT_W = (COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W;

	typedef logic [COUNT_WIDTH-1:0] cnt_t;
	typedef logic [SUM_W-1:0]       sum_t;

	function automatic cnt_t sat_inc(input cnt_t c);
		return (c == {COUNT_WIDTH{1'b1}}) ? c : c + cnt_t'(1);
	endfunction

	function automatic total_t clip_total(input cnt_t c);
		logic [EXT_W-1:0] ext;
		ext = EXT_W'(c);
		return (ext > EXT_W'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(ext);
	endfunction

	// Configuration registers
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vote_rule     <= 1'b0;
			cfg_q.sat_min       <= RST_SAT_MIN;
			cfg_q.val_min       <= RST_VAL_MIN;
			cfg_q.val_max       <= RST_VAL_MAX;
			cfg_q.purple_hue_lo <= RST_PURPLE_HUE_LO;
			cfg_q.purple_hue_hi <= RST_PURPLE_HUE_HI;
			cfg_q.blue_hue_lo   <= RST_BLUE_HUE_LO;
			cfg_q.blue_hue_hi   <= RST_BLUE_HUE_HI;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_VOTE_RULE:     cfg_q.vote_rule     <= cfg_data[0];
				REG_SAT_MIN:       cfg_q.sat_min       <= cfg_data;
				REG_VAL_MIN:       cfg_q.val_min       <= cfg_data;
				REG_VAL_MAX:       cfg_q.val_max       <= cfg_data;
				REG_PURPLE_HUE_LO: cfg_q.purple_hue_lo <= cfg_data;
				REG_PURPLE_HUE_HI: cfg_q.purple_hue_hi <= cfg_data;
				REG_BLUE_HUE_LO:   cfg_q.blue_hue_lo   <= cfg_data;
				REG_BLUE_HUE_HI:   cfg_q.blue_hue_hi   <= cfg_data;
			endcase
		end
	end

	// Flow control: only last pixels need room downstream
	logic s1_valid_s1, s2_valid_s2, out_valid_q;
	logic hue_last_s1;
	logic out_free, s2_free, s2_move, s1_move, s1_free;

	assign out_free  = !out_valid_q || res.ready;
	assign s2_move   = s2_valid_s2 && out_free;
	assign s2_free   = !s2_valid_s2 || out_free;
	assign s1_move   = s1_valid_s1 && (!hue_last_s1 || s2_free);
	assign s1_free   = !s1_valid_s1 || s1_move;
	assign pix.ready = s1_free;

	// Stage 1: input register
	pix_t hue_s1, sat_s1, val_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (s1_free) begin
			s1_valid_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix.valid && s1_free) begin
			hue_s1      <= pix.hue;
			sat_s1      <= pix.sat;
			val_s1      <= pix.val;
			hue_last_s1 <= pix.last_pixel;
		end
	end

	// Pixel classification against the hue windows
	logic dull, classify, in_purple, in_red, in_blue;

	always_comb begin
		dull      = (sat_s1 < cfg_q.sat_min) || (val_s1 < cfg_q.val_min) ||
		            (val_s1 > cfg_q.val_max);
		classify  = !(dull && !cfg_q.vote_rule);
		in_purple = (hue_s1 >= cfg_q.purple_hue_lo) && (hue_s1 <= cfg_q.purple_hue_hi);
		in_red    = ((hue_s1 >= RED_HUE_LO) && (hue_s1 <= RED_HUE_HI)) ||
		            (hue_s1 <= RED_WRAP_HI);
		in_blue   = (hue_s1 >= cfg_q.blue_hue_lo) && (hue_s1 <= cfg_q.blue_hue_hi);
	end

	// Counter next values, purple over red over blue
	cnt_t red_q, blue_q, purple_q, dull_q;
	cnt_t red_nxt, blue_nxt, purple_nxt, dull_nxt;

	always_comb begin
		red_nxt    = red_q;
		blue_nxt   = blue_q;
		purple_nxt = purple_q;
		dull_nxt   = (dull && cfg_q.vote_rule) ? sat_inc(dull_q) : dull_q;
		if (classify) begin
			priority if (in_purple) begin
				purple_nxt = sat_inc(purple_q);
			end else if (in_red) begin
				red_nxt = sat_inc(red_q);
			end else if (in_blue) begin
				blue_nxt = sat_inc(blue_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q    <= '0;
			blue_q   <= '0;
			purple_q <= '0;
			dull_q   <= '0;
		end else if (s1_move) begin
			if (hue_last_s1) begin
				red_q    <= '0;
				blue_q   <= '0;
				purple_q <= '0;
				dull_q   <= '0;
			end else begin
				red_q    <= red_nxt;
				blue_q   <= blue_nxt;
				purple_q <= purple_nxt;
				dull_q   <= dull_nxt;
			end
		end
	end

	// Stage 2: snapshot of the region's counts
	cnt_t red_s2, blue_s2, purple_s2, dull_s2;
	logic rule_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_s2 <= 1'b0;
		end else if (s2_free) begin
			s2_valid_s2 <= s1_move && hue_last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && hue_last_s1 && s2_free) begin
			red_s2    <= red_nxt;
			blue_s2   <= blue_nxt;
			purple_s2 <= purple_nxt;
			dull_s2   <= dull_nxt;
			rule_s2   <= cfg_q.vote_rule;
		end
	end

	// Colour vote
	sum_t r_x, b_x, p_x, d_x, rbp_sum, bp_sum, rp_sum, p2, p3, r2, b2;
	color_t color_d;

	always_comb begin
		r_x     = SUM_W'(red_s2);
		b_x     = SUM_W'(blue_s2);
		p_x     = SUM_W'(purple_s2);
		d_x     = SUM_W'(dull_s2);
		rbp_sum = r_x + b_x + p_x;
		bp_sum  = b_x + p_x;
		rp_sum  = r_x + p_x;
		p2      = p_x << 1;
		p3      = p2 + p_x;
		r2      = r_x << 1;
		b2      = b_x << 1;
		priority if (rule_s2 && (rbp_sum <= d_x)) begin
			color_d = COLOR_NONE;
		end else if (!rule_s2 && (p2 > r_x) && (p2 > b_x)) begin
			color_d = COLOR_PURPLE;
		end else if (rule_s2 && (p3 > r2) && (p3 > b2)) begin
			color_d = COLOR_PURPLE;
		end else if ((r_x >= bp_sum) && (red_s2 != '0)) begin
			color_d = COLOR_RED;
		end else if (b_x > rp_sum) begin
			color_d = COLOR_BLUE;
		end else begin
			color_d = COLOR_NONE;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s2_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			res.color        <= color_d;
			res.red_total    <= clip_total(red_s2);
			res.blue_total   <= clip_total(blue_s2);
			res.purple_total <= clip_total(purple_s2);
		end
	end

	assign res.valid = out_valid_q;

endmodule

`default_nettype wire

// ===== sv/hcvc_checker.sv =====
// hcvc_checker: port-level assertions on the classifier's result channel,
// bound to hsv_color_vote_classifier_top. Depends on hcvc_pkg.
`default_nettype none

module hcvc_checker
	import hcvc_pkg::*;
(
	input wire logic   clk,
	input wire logic   arst_n,
	input wire logic   res_valid,
	input wire logic   res_ready,
	input wire color_t res_color,
	input wire total_t res_red_total,
	input wire total_t res_blue_total,
	input wire total_t res_purple_total
);

	// A stalled result holds its colour
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_color))
		else $error("result changed while stalled");

	// Each winning colour must have seen at least one pixel
	a_red: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_color == COLOR_RED) |-> res_red_total != '0)
		else $error("red vote with no red pixels");

	a_blue: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_color == COLOR_BLUE) |-> res_blue_total != '0)
		else $error("blue vote with no blue pixels");

	a_purple: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_color == COLOR_PURPLE) |-> res_purple_total != '0)
		else $error("purple vote with no purple pixels");

endmodule

bind hsv_color_vote_classifier_top hcvc_checker u_hcvc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_color        (res.color),
	.res_red_total    (res.red_total),
	.res_blue_total   (res.blue_total),
	.res_purple_total (res.purple_total)
);

`default_nettype wire

// ===== verif/hcvc_colour_vote_check.sv =====
`timescale 1ns / 1ps
// hcvc_colour_vote_check: watches the pixel, result and register ports of the
// HSV colour vote classifier, predicts each region's verdict and compares it.
// Depends on hcvc_pkg, hcvc_pixel_if and hcvc_result_if.

module hcvc_colour_vote_check
	import hcvc_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	hcvc_pixel_if                 pix,
	hcvc_result_if                res,
	output int unsigned           verdicts_pending,
	output int unsigned           mismatch_count
);

	localparam longint unsigned CNT_MAX = (64'd1 << COUNT_WIDTH) - 64'd1;

	localparam cfg_t CFG_RESET = '{
		vote_rule:     1'b0,
		sat_min:       RST_SAT_MIN,
		val_min:       RST_VAL_MIN,
		val_max:       RST_VAL_MAX,
		purple_hue_lo: RST_PURPLE_HUE_LO,
		purple_hue_hi: RST_PURPLE_HUE_HI,
		blue_hue_lo:   RST_BLUE_HUE_LO,
		blue_hue_hi:   RST_BLUE_HUE_HI
	};

	typedef struct packed {
		color_t color;
		total_t red;
		total_t blue;
		total_t purple;
	} verdict_t;

	// Shadow registers and running tallies of the region in progress
	cfg_t            cfg = CFG_RESET;
	longint unsigned red_cnt = 0;
	longint unsigned blue_cnt = 0;
	longint unsigned purple_cnt = 0;
	longint unsigned dull_cnt = 0;
	verdict_t        awaited_verdicts[$];

	function automatic longint unsigned bump(input longint unsigned c);
		return (c < CNT_MAX) ? c + 64'd1 : c;
	endfunction

	function automatic total_t clip_total(input longint unsigned c);
		return (c > TOTAL_MAX) ? TOTAL_MAX : total_t'(c);
	endfunction

	// Vote on the saturated tallies; the dull test only exists under the box rule
	function automatic color_t decide_colour(input logic rule, input longint unsigned r,
			input longint unsigned b, input longint unsigned p, input longint unsigned d);
		if (rule && (r + b + p) <= d)
			return COLOR_NONE;
		if (!rule && 2 * p > r && 2 * p > b)
			return COLOR_PURPLE;
		if (rule && 3 * p > 2 * r && 3 * p > 2 * b)
			return COLOR_PURPLE;
		if (r >= b + p && r != 0)
			return COLOR_RED;
		if (b > r + p)
			return COLOR_BLUE;
		return COLOR_NONE;
	endfunction

	// Count one pixel; on the last pixel queue the verdict and start a new region
	task automatic tally_pixel(input pix_t h, input pix_t s, input pix_t v, input logic last);
		logic     dull;
		verdict_t vd;
		dull = (s < cfg.sat_min) || (v < cfg.val_min) || (v > cfg.val_max);
		if (dull && cfg.vote_rule)
			dull_cnt = bump(dull_cnt);
		if (!dull || cfg.vote_rule) begin
			// purple beats red, red beats blue where windows overlap
			if (h >= cfg.purple_hue_lo && h <= cfg.purple_hue_hi)
				purple_cnt = bump(purple_cnt);
			else if ((h >= RED_HUE_LO && h <= RED_HUE_HI) || h <= RED_WRAP_HI)
				red_cnt = bump(red_cnt);
			else if (h >= cfg.blue_hue_lo && h <= cfg.blue_hue_hi)
				blue_cnt = bump(blue_cnt);
		end
		if (last) begin
			vd.color  = decide_colour(cfg.vote_rule, red_cnt, blue_cnt, purple_cnt, dull_cnt);
			vd.red    = clip_total(red_cnt);
			vd.blue   = clip_total(blue_cnt);
			vd.purple = clip_total(purple_cnt);
			awaited_verdicts.push_back(vd);
			red_cnt    = 0;
			blue_cnt   = 0;
			purple_cnt = 0;
			dull_cnt   = 0;
		end
	endtask

	// Register writes, pixel transactions and result transactions, in edge order
	always @(posedge clk or negedge arst_n) begin
		verdict_t got;
		verdict_t want;
		if (!arst_n) begin
			cfg            = CFG_RESET;
			red_cnt        = 0;
			blue_cnt       = 0;
			purple_cnt     = 0;
			dull_cnt       = 0;
			mismatch_count = 0;
			awaited_verdicts.delete();
			verdicts_pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_VOTE_RULE:     cfg.vote_rule     = cfg_data[0];
					REG_SAT_MIN:       cfg.sat_min       = cfg_data;
					REG_VAL_MIN:       cfg.val_min       = cfg_data;
					REG_VAL_MAX:       cfg.val_max       = cfg_data;
					REG_PURPLE_HUE_LO: cfg.purple_hue_lo = cfg_data;
					REG_PURPLE_HUE_HI: cfg.purple_hue_hi = cfg_data;
					REG_BLUE_HUE_LO:   cfg.blue_hue_lo   = cfg_data;
					REG_BLUE_HUE_HI:   cfg.blue_hue_hi   = cfg_data;
					default: ;
				endcase
			end

			if (pix.valid && pix.ready)
				tally_pixel(pix.hue, pix.sat, pix.val, pix.last_pixel);

			if (res.valid && res.ready) begin
				got = '{res.color, res.red_total, res.blue_total, res.purple_total};
				if (awaited_verdicts.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: result with none awaited: colour %0d R %0d B %0d P %0d",
							$time, got.color, got.red, got.blue, got.purple);
				end else begin
					want = awaited_verdicts.pop_front();
					if (got.color !== want.color || got.red !== want.red ||
							got.blue !== want.blue || got.purple !== want.purple) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"%0t: result mismatch: expected colour %0d R %0d B %0d P %0d,",
								" got colour %0d R %0d B %0d P %0d"}, $time,
								want.color, want.red, want.blue, want.purple,
								got.color, got.red, got.blue, got.purple);
					end
				end
			end

			verdicts_pending <= awaited_verdicts.size();
		end
	end

endmodule

// ===== verif/hsv_color_vote_classifier_top_tb.sv =====
`timescale 1ns / 1ps
// hsv_color_vote_classifier_top_tb: clock, reset, register settings, pixel
// stimulus and result back-pressure; verdict from hcvc_colour_vote_check.
// Depends on hcvc_pkg, both channel interfaces, the block and the checker.

module hsv_color_vote_classifier_top_tb;
	import hcvc_pkg::*;

	localparam int unsigned COUNT_W         = 16;
	localparam int unsigned PIPE_LAT        = 8;
	localparam int unsigned HOLD_OFF_CYCLES = 300;
	localparam int unsigned PHASE_ITEMS     = 110;

	typedef enum int {PK_RED, PK_PURPLE, PK_BLUE, PK_STRAY, PK_DULL, PK_ANY} pix_kind_e;

	localparam cfg_t CFG_DEFAULT = '{
		vote_rule:     1'b0,
		sat_min:       RST_SAT_MIN,
		val_min:       RST_VAL_MIN,
		val_max:       RST_VAL_MAX,
		purple_hue_lo: RST_PURPLE_HUE_LO,
		purple_hue_hi: RST_PURPLE_HUE_HI,
		blue_hue_lo:   RST_BLUE_HUE_LO,
		blue_hue_hi:   RST_BLUE_HUE_HI
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  gaps_on;
	int unsigned           holdoff_req;
	int unsigned           verdicts_pending;
	int unsigned           mismatch_count;
	cfg_t                  cur_cfg;

	hcvc_pixel_if  pix_ch ();
	hcvc_result_if res_ch ();

	hsv_color_vote_classifier_top #(.COUNT_WIDTH(COUNT_W)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix       (pix_ch),
		.res       (res_ch)
	);

	hcvc_colour_vote_check #(.COUNT_WIDTH(COUNT_W)) vote_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.pix              (pix_ch),
		.res              (res_ch),
		.verdicts_pending (verdicts_pending),
		.mismatch_count   (mismatch_count)
	);

	always #2 clk = ~clk;

	// Result side: random stalls, or a long hold-off when one is requested
	initial begin
		int unsigned holdoff_done;
		holdoff_done = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_req != holdoff_done) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				holdoff_done++;
			end else begin
				res_ch.ready <= !(gaps_on && $urandom_range(0, 99) < 33);
			end
		end
	end

	// Offer one pixel, with optional idle cycles first; returns on acceptance
	task automatic send_pixel(input pix_t h, input pix_t s, input pix_t v, input logic last);
		while (gaps_on && $urandom_range(0, 99) < 33) begin
			pix_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pix_ch.valid      <= 1'b1;
		pix_ch.hue        <= h;
		pix_ch.sat        <= s;
		pix_ch.val        <= v;
		pix_ch.last_pixel <= last;
		@(posedge clk);
		while (!pix_ch.ready) @(posedge clk);
	endtask

	// Value in [lo, hi], often right on a bound; anything if the range is empty
	function automatic pix_t pick_in(input int lo, input int hi);
		int r;
		if (lo > hi)
			return pix_t'($urandom_range(0, 255));
		r = $urandom_range(0, 3);
		if (r == 0)
			return pix_t'(lo);
		if (r == 1)
			return pix_t'(hi);
		return pix_t'($urandom_range(lo, hi));
	endfunction

	task automatic send_kind(input pix_kind_e kind, input logic last);
		pix_t h;
		pix_t s;
		pix_t v;
		h = pix_t'($urandom_range(0, 255));
		s = pick_in(cur_cfg.sat_min, 255);
		v = pick_in(cur_cfg.val_min, cur_cfg.val_max);
		case (kind)
			PK_RED: begin
				if ($urandom_range(0, 1))
					h = pick_in(RED_HUE_LO, RED_HUE_HI);
				else
					h = pick_in(0, RED_WRAP_HI);
			end
			PK_PURPLE: h = pick_in(cur_cfg.purple_hue_lo, cur_cfg.purple_hue_hi);
			PK_BLUE:   h = pick_in(cur_cfg.blue_hue_lo, cur_cfg.blue_hue_hi);
			PK_DULL: begin
				// break one of the three brightness limits where it can be broken
				case ($urandom_range(0, 2))
					0: if (cur_cfg.sat_min > 0) s = pick_in(0, int'(cur_cfg.sat_min) - 1);
					1: if (cur_cfg.val_min > 0) v = pick_in(0, int'(cur_cfg.val_min) - 1);
					default: if (cur_cfg.val_max < 255) v = pick_in(int'(cur_cfg.val_max) + 1, 255);
				endcase
			end
			PK_ANY: begin
				s = pix_t'($urandom_range(0, 255));
				v = pix_t'($urandom_range(0, 255));
			end
			default: ;
		endcase
		send_pixel(h, s, v, last);
	endtask

	// A region leans towards one kind of pixel, mixed with others, dull pixels and noise
	task automatic send_region(input int unsigned len);
		pix_kind_e dom;
		pix_kind_e kind;
		int        r;
		dom = pix_kind_e'($urandom_range(0, 3));
		for (int unsigned i = 0; i < len; i++) begin
			r = $urandom_range(0, 9);
			if (r < 5)
				kind = dom;
			else if (r < 7)
				kind = pix_kind_e'($urandom_range(0, 3));
			else if (r < 9)
				kind = PK_DULL;
			else
				kind = PK_ANY;
			send_kind(kind, i == len - 1);
		end
	endtask

	// Stop offering, wait for every awaited result, then let the pipeline empty
	task automatic settle();
		pix_ch.valid <= 1'b0;
		@(posedge clk);
		while (verdicts_pending != 0) @(posedge clk);
		repeat (PIPE_LAT) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic load_settings(input cfg_t c);
		put_reg(REG_VOTE_RULE, {7'($urandom_range(0, 127)), c.vote_rule});
		put_reg(REG_SAT_MIN, c.sat_min);
		put_reg(REG_VAL_MIN, c.val_min);
		put_reg(REG_VAL_MAX, c.val_max);
		put_reg(REG_PURPLE_HUE_LO, c.purple_hue_lo);
		put_reg(REG_PURPLE_HUE_HI, c.purple_hue_hi);
		put_reg(REG_BLUE_HUE_LO, c.blue_hue_lo);
		put_reg(REG_BLUE_HUE_HI, c.blue_hue_hi);
		cfg_we  <= 1'b0;
		cur_cfg  = c;
	endtask

	task automatic run_phase(input cfg_t c, input logic gaps, input logic squeeze);
		int unsigned sent;
		int unsigned len;
		settle();
		load_settings(c);
		gaps_on <= gaps;
		// short regions during a hold-off so held results back up the input
		if (squeeze)
			holdoff_req <= holdoff_req + 1;
		sent = 0;
		while (sent < PHASE_ITEMS) begin
			len = squeeze ? $urandom_range(1, 2) : $urandom_range(1, 12);
			send_region(len);
			sent += len;
		end
	endtask

	// Main sequence
	initial begin
		cfg_t c;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = '0;
		cfg_data          = '0;
		pix_ch.valid      = 1'b0;
		pix_ch.hue        = '0;
		pix_ch.sat        = '0;
		pix_ch.val        = '0;
		pix_ch.last_pixel = 1'b0;
		gaps_on           = 1'b1;
		holdoff_req       = 0;
		cur_cfg           = CFG_DEFAULT;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings, pair rule: window bounds, brightness limits, hue above 180
		send_pixel(8'd0, 8'd255, 8'd200, 1'b0);
		send_pixel(8'd10, 8'd43, 8'd46, 1'b0);
		send_pixel(8'd11, 8'd100, 8'd100, 1'b0);
		send_pixel(8'd180, 8'd100, 8'd240, 1'b0);
		send_pixel(8'd156, 8'd100, 8'd100, 1'b0);
		send_pixel(8'd155, 8'd100, 8'd100, 1'b0);
		send_pixel(8'd125, 8'd100, 8'd100, 1'b0);
		send_pixel(8'd124, 8'd100, 8'd100, 1'b0);
		send_pixel(8'd100, 8'd100, 8'd100, 1'b0);
		send_pixel(8'd181, 8'd100, 8'd100, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd0, 8'd42, 8'd100, 1'b0);
		send_pixel(8'd0, 8'd100, 8'd45, 1'b0);
		send_pixel(8'd200, 8'd0, 8'd0, 1'b1);
		// empty region, then clean blue and purple regions
		send_pixel(8'd50, 8'd100, 8'd100, 1'b1);
		send_pixel(8'd110, 8'd100, 8'd100, 1'b0);
		send_pixel(8'd110, 8'd100, 8'd100, 1'b1);
		send_pixel(8'd140, 8'd100, 8'd100, 1'b1);

		// Box rule: dull pixels dominate, then a red win
		c = CFG_DEFAULT;
		c.vote_rule = 1'b1;
		settle();
		load_settings(c);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		send_pixel(8'd130, 8'd100, 8'd100, 1'b0);
		send_pixel(8'd0, 8'd100, 8'd100, 1'b0);
		send_pixel(8'd0, 8'd100, 8'd100, 1'b1);

		// Rule switched part way through a region
		send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
		send_pixel(8'd130, 8'd0, 8'd100, 1'b0);
		settle();
		load_settings(CFG_DEFAULT);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd130, 8'd100, 8'd100, 1'b1);

		// Random regions under a range of settings
		run_phase(CFG_DEFAULT, 1'b1, 1'b0);
		c = CFG_DEFAULT;
		c.vote_rule = 1'b1;
		run_phase(c, 1'b0, 1'b0);
		c = CFG_DEFAULT;
		c.sat_min = 8'd0;
		c.val_min = 8'd0;
		c.val_max = 8'd255;
		run_phase(c, 1'b1, 1'b1);
		c = '{vote_rule: 1'b1, sat_min: 8'd255, val_min: 8'd255, val_max: 8'd0,
			purple_hue_lo: 8'd150, purple_hue_hi: 8'd180, blue_hue_lo: 8'd0, blue_hue_hi: 8'd180};
		run_phase(c, 1'b1, 1'b0);
		c = CFG_DEFAULT;
		c.purple_hue_lo = 8'd180;
		c.purple_hue_hi = 8'd0;
		c.blue_hue_lo   = 8'd124;
		c.blue_hue_hi   = 8'd100;
		run_phase(c, 1'b1, 1'b0);
		for (int k = 0; k < 3; k++) begin
			c.vote_rule     = 1'($urandom_range(0, 1));
			c.sat_min       = pix_t'($urandom_range(0, 255));
			c.val_min       = pix_t'($urandom_range(0, 128));
			c.val_max       = pix_t'($urandom_range(64, 255));
			c.purple_hue_lo = pix_t'($urandom_range(0, 180));
			c.purple_hue_hi = pix_t'($urandom_range(0, 180));
			c.blue_hue_lo   = pix_t'($urandom_range(0, 180));
			c.blue_hue_hi   = pix_t'($urandom_range(0, 180));
			run_phase(c, 1'b1, 1'b0);
		end

		settle();
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Run limit
	initial begin
		#4_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
